>>> rtl/rtak_pkg.sv
// shared types and constants for the i2c target register access block
package rtak_pkg;

    localparam int EV_W    = 3;
    localparam int CODE_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;

    // bus event codes, codes six and seven mean nothing
    typedef enum logic [EV_W-1:0] {
        EV_ADDR     = 3'd0,
        EV_BYTE     = 3'd1,
        EV_TX_EMPTY = 3'd2,
        EV_STOP     = 3'd3,
        EV_NACK     = 3'd4,
        EV_BUS_ERR  = 3'd5
    } event_t;

    // one bus event as held in the input register
    typedef struct packed {
        logic [EV_W-1:0]   req_type;
        logic [CODE_W-1:0] match_code;
        logic              dir_read;
        logic [BYTE_W-1:0] rx_byte;
    } req_t;

    // decoded step result waiting for the store read data
    typedef struct packed {
        logic              tx_valid;
        logic              from_mem;
        logic              fetch;
        logic [BYTE_W-1:0] tx_byte;
        logic              txn_end;
        logic              halted;
    } stage_t;

endpackage

>>> rtl/rtak_if.sv
// valid/ready channels for bus events and step results
interface rtak_req_if
    import rtak_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   req_type;
    logic [CODE_W-1:0] match_code;
    logic              dir_read;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output req_type, output match_code, output dir_read,
                    output rx_byte, input ready);
    modport sink   (input valid, input req_type, input match_code, input dir_read,
                    input rx_byte, output ready);
endinterface

interface rtak_rsp_if
    import rtak_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              txn_end;
    logic              halted;

    modport source (output valid, output tx_valid, output tx_byte, output txn_end,
                    output halted, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input txn_end,
                    input halted, output ready);
endinterface

>>> rtl/rtak_store.sv
// register store: one write port, one read port with registered read data
module rtak_store
    import rtak_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/rtak_ctrl.sv
// transaction sequencer: phase, store address tracking and data word
module rtak_ctrl
    import rtak_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [CODE_W-1:0]              own_address,
    input  logic                           fire,
    input  req_t                           item,
    input  logic                           fwd,
    input  logic                           drain,
    input  logic [WORD_W-1:0]              mem_q,
    output stage_t                         stage,
    output logic                           rd_en,
    output logic [$clog2(STORE_DEPTH)-1:0] rd_slot,
    output logic                           wr_en,
    output logic [$clog2(STORE_DEPTH)-1:0] wr_slot,
    output logic [WORD_W-1:0]              wr_data
);

    localparam int SLOT_W = $clog2(STORE_DEPTH);
    localparam int SUM_W  = SLOT_W + 1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_REG_LO, PH_REG_HI, PH_REG_DONE, PH_WR_HIGH,
        PH_WR_NEXT, PH_RD_HIGH, PH_RD_LOW, PH_HALTED
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   base_lo_reg, base_lo_next;
    logic [WORD_W-1:0]   addr_reg, addr_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [WORD_W-1:0]   data_word_reg, data_word_next;

    logic [WORD_W-1:0]   dw_eff;
    logic [WORD_W-1:0]   dw_step;
    logic [SLOT_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   hi_mod [256];
    logic [SLOT_W-1:0]   lo_mod [256];
    logic [SUM_W-1:0]    slot_sum;
    logic [SLOT_W-1:0]   base_slot;
    logic                mine;
    logic                fault;
    logic                reading;

    // residue tables for the two bytes of the register address
    for (genvar g = 0; g < 256; g++)
    begin : g_mod_tab
        assign hi_mod[g] = SLOT_W'((g * 256) % STORE_DEPTH);
        assign lo_mod[g] = SLOT_W'(g % STORE_DEPTH);
    end

    // store slot of a freshly received register address
    assign slot_sum  = {1'b0, hi_mod[item.rx_byte]} + {1'b0, lo_mod[base_lo_reg]};
    assign base_slot = (slot_sum >= SUM_W'(STORE_DEPTH))
                       ? SLOT_W'(slot_sum - SUM_W'(STORE_DEPTH))
                       : SLOT_W'(slot_sum);

    // next slot, wrapping at the store depth and at the end of the address space
    assign slot_inc = (slot_reg == SLOT_W'(STORE_DEPTH - 1) || addr_reg == '1)
                      ? '0 : slot_reg + 1'b1;

    // word fetched by the step ahead is still in the read register
    assign dw_eff  = fwd ? mem_q : data_word_reg;
    assign mine    = (item.match_code == own_address);
    assign reading = (phase_reg == PH_RD_HIGH) || (phase_reg == PH_RD_LOW);

    // event decode
    always_comb
    begin
        phase_next     = phase_reg;
        base_lo_next   = base_lo_reg;
        addr_next      = addr_reg;
        slot_next      = slot_reg;
        dw_step        = dw_eff;
        stage          = '0;
        fault          = 1'b0;
        rd_en          = 1'b0;
        rd_slot        = slot_reg;
        wr_en          = 1'b0;
        wr_slot        = slot_reg;
        wr_data        = {item.rx_byte, dw_eff[BYTE_W-1:0]};

        if (phase_reg != PH_HALTED)
        begin
            unique case (event_t'(item.req_type))
                EV_ADDR:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (mine && item.dir_read)
                            fault = 1'b1;
                        else if (mine)
                            phase_next = PH_REG_LO;
                    end
                    else if (phase_reg == PH_REG_DONE)
                    begin
                        if (mine && !item.dir_read)
                            fault = 1'b1;
                        else if (mine)
                        begin
                            rd_en          = 1'b1;
                            stage.tx_valid = 1'b1;
                            stage.from_mem = 1'b1;
                            stage.fetch    = 1'b1;
                            phase_next     = PH_RD_HIGH;
                        end
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                EV_BYTE:
                begin
                    unique case (phase_reg) inside
                        PH_REG_LO:
                        begin
                            base_lo_next = item.rx_byte;
                            phase_next   = PH_REG_HI;
                        end
                        PH_REG_HI:
                        begin
                            addr_next  = {item.rx_byte, base_lo_reg};
                            slot_next  = base_slot;
                            phase_next = PH_REG_DONE;
                        end
                        PH_REG_DONE, PH_WR_NEXT:
                        begin
                            dw_step    = {dw_eff[WORD_W-1:BYTE_W], item.rx_byte};
                            phase_next = PH_WR_HIGH;
                        end
                        PH_WR_HIGH:
                        begin
                            dw_step    = {item.rx_byte, dw_eff[BYTE_W-1:0]};
                            wr_en      = 1'b1;
                            addr_next  = addr_reg + 1'b1;
                            slot_next  = slot_inc;
                            phase_next = PH_WR_NEXT;
                        end
                        default:
                        begin
                            fault = 1'b1;
                        end
                    endcase
                end
                EV_TX_EMPTY:
                begin
                    if (phase_reg == PH_RD_HIGH)
                    begin
                        stage.tx_valid = 1'b1;
                        stage.tx_byte  = dw_eff[WORD_W-1:BYTE_W];
                        stage.fetch    = 1'b1;
                        rd_en          = 1'b1;
                        rd_slot        = slot_inc;
                        addr_next      = addr_reg + 1'b1;
                        slot_next      = slot_inc;
                        phase_next     = PH_RD_LOW;
                    end
                    else if (phase_reg == PH_RD_LOW)
                    begin
                        stage.tx_valid = 1'b1;
                        stage.tx_byte  = dw_eff[BYTE_W-1:0];
                        phase_next     = PH_RD_HIGH;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                EV_STOP:
                begin
                    if (reading || phase_reg == PH_WR_NEXT)
                    begin
                        stage.txn_end = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    else if (phase_reg != PH_IDLE && phase_reg != PH_REG_DONE)
                    begin
                        fault = 1'b1;
                    end
                end
                EV_NACK:
                begin
                    if (reading)
                    begin
                        stage.txn_end = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        fault = 1'b1;
                    end
                end
                EV_BUS_ERR:
                begin
                    fault = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (fault)
        begin
            phase_next = PH_HALTED;
            stage      = '0;
        end
        stage.halted = (phase_next == PH_HALTED);

        // a fetched word lands once its step leaves the read stage
        if (fire)
            data_word_next = dw_step;
        else if (fwd && drain)
            data_word_next = mem_q;
        else
            data_word_next = data_word_reg;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            base_lo_reg   <= '0;
            addr_reg      <= '0;
            slot_reg      <= '0;
            data_word_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg   <= phase_next;
                base_lo_reg <= base_lo_next;
                addr_reg    <= addr_next;
                slot_reg    <= slot_next;
            end
            data_word_reg <= data_word_next;
        end
    end

    // halt is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALTED) |=> (phase_reg == PH_HALTED))
        else $error("halted state left without reset");

    // a step never reads and writes the store at once
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(rd_en && wr_en))
        else $error("store read and write in one step");

    // store is only written in the high byte phase of a data word
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && wr_en) |-> (phase_reg == PH_WR_HIGH))
        else $error("store write outside a data word");

endmodule

>>> rtl/i2c_target_register_access_core.sv
// i2c target register access: event pipeline, store and result register
//
//   channel   dir  transaction                                   handshake
//   req       in   req_type, match_code, dir_read, rx_byte       valid/ready
//   rsp       out  tx_valid, tx_byte, txn_end, halted            valid/ready
//   cfg       in   own_address                                   cfg_we, no wait
//
// One transaction per cycle is accepted while the result side keeps taking results;
// its result passes the input register, the read stage register and the result register.
// After reset a clearing pass zeroes every store slot with req.ready low;
// configuration writes are taken during it.
// When rsp.ready is low the result register holds and the stages behind it
// keep filling, so up to three transactions are held before req.ready drops.
module i2c_target_register_access_core
    import rtak_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CODE_W-1:0] cfg_wdata,
    rtak_req_if.sink          req,
    rtak_rsp_if.source        rsp
);

    localparam int SLOT_W = $clog2(STORE_DEPTH);

    logic [CODE_W-1:0] own_addr_reg;
    logic              clear_busy_reg;
    logic [SLOT_W-1:0] clear_cnt_reg;

    logic              s1_valid_reg;
    req_t              s1_reg;
    logic              s2_valid_reg;
    stage_t            s2_reg;
    logic              out_valid_reg;
    logic              out_tx_valid_reg;
    logic [BYTE_W-1:0] out_tx_byte_reg;
    logic              out_txn_end_reg;
    logic              out_halted_reg;

    logic              out_adv;
    logic              s2_adv;
    logic              s1_adv;
    logic              fire;
    stage_t            stage;
    logic              ctl_rd_en;
    logic [SLOT_W-1:0] ctl_rd_slot;
    logic              ctl_wr_en;
    logic [SLOT_W-1:0] ctl_wr_slot;
    logic [WORD_W-1:0] ctl_wr_data;
    logic              mem_wr_en;
    logic [SLOT_W-1:0] mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic [WORD_W-1:0] mem_q;

    // stage advance, each stage moves when the one after it has room
    assign out_adv   = !out_valid_reg || rsp.ready;
    assign s2_adv    = !s2_valid_reg || out_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign fire      = s1_valid_reg && s2_adv;
    assign req.ready = s1_adv && !clear_busy_reg;

    // own address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_addr_reg <= '0;
        else if (cfg_we)
            own_addr_reg <= cfg_wdata;
    end

    // store clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == SLOT_W'(STORE_DEPTH - 1))
                clear_busy_reg <= 1'b0;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_adv)
            s1_valid_reg <= req.valid && req.ready;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg.req_type   <= req.req_type;
            s1_reg.match_code <= req.match_code;
            s1_reg.dir_read   <= req.dir_read;
            s1_reg.rx_byte    <= req.rx_byte;
        end
    end

    rtak_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .own_address (own_addr_reg),
        .fire        (fire),
        .item        (s1_reg),
        .fwd         (s2_valid_reg && s2_reg.fetch),
        .drain       (out_adv),
        .mem_q       (mem_q),
        .stage       (stage),
        .rd_en       (ctl_rd_en),
        .rd_slot     (ctl_rd_slot),
        .wr_en       (ctl_wr_en),
        .wr_slot     (ctl_wr_slot),
        .wr_data     (ctl_wr_data)
    );

    // store write select, clearing pass first
    assign mem_wr_en   = clear_busy_reg || (fire && ctl_wr_en);
    assign mem_wr_addr = clear_busy_reg ? clear_cnt_reg : ctl_wr_slot;
    assign mem_wr_data = clear_busy_reg ? '0 : ctl_wr_data;

    rtak_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (fire && ctl_rd_en),
        .rd_addr (ctl_rd_slot),
        .rd_data (mem_q)
    );

    // read stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_adv)
            s2_valid_reg <= fire;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            s2_reg <= stage;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
        begin
            out_tx_valid_reg <= s2_reg.tx_valid;
            out_tx_byte_reg  <= s2_reg.from_mem ? mem_q[BYTE_W-1:0] : s2_reg.tx_byte;
            out_txn_end_reg  <= s2_reg.txn_end;
            out_halted_reg   <= s2_reg.halted;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.tx_valid = out_tx_valid_reg;
    assign rsp.tx_byte  = out_tx_byte_reg;
    assign rsp.txn_end  = out_txn_end_reg;
    assign rsp.halted   = out_halted_reg;

    // nothing enters while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !(req.valid && req.ready) && !s1_valid_reg)
        else $error("transaction accepted during clearing pass");

    // an idle transmitter slot carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.tx_valid) |-> (rsp.tx_byte == '0))
        else $error("byte without transmit valid");

    // fetched word stays put while its step waits in the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_reg.fetch && !out_adv) |=> $stable(mem_q))
        else $error("store read data lost under stall");

    // a halted result never carries a byte or an end mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.halted) |-> (!rsp.tx_valid && !rsp.txn_end))
        else $error("activity reported while halted");

endmodule

>>> tb/tb_i2c_target_register_access_core.sv
// testbench for the i2c target register access core with a behavioral predictor
module tb_i2c_target_register_access_core;
    import rtak_pkg::*;

    localparam int STORE_DEPTH   = 1024;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_EVENTS = 1900;
    localparam int SETTLE_CYCLES = 6;
    localparam int PRINT_LIMIT   = 100;

    // event codes the block must ignore
    localparam logic [EV_W-1:0] EV_UNDEF_A = 3'd6;
    localparam logic [EV_W-1:0] EV_UNDEF_B = 3'd7;

    typedef enum logic [3:0] {
        P_IDLE,
        P_REG_LO,
        P_REG_HI,
        P_REG_DONE,
        P_WR_HIGH,
        P_WR_NEXT,
        P_RD_HIGH,
        P_RD_LOW,
        P_HALTED
    } target_phase_t;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              txn_end;
        logic              halted;
    } bus_reply_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CODE_W-1:0] cfg_wdata;

    rtak_req_if req_ch();
    rtak_rsp_if rsp_ch();

    i2c_target_register_access_core #(
        .STORE_DEPTH(STORE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // predicted target state
    logic [CODE_W-1:0] own_addr;
    target_phase_t     phase;
    logic [WORD_W-1:0] base_addr;
    logic [WORD_W-1:0] word_idx;
    logic [WORD_W-1:0] data_word;
    logic [WORD_W-1:0] reg_store [STORE_DEPTH];

    bus_reply_t pending_replies[$];
    bus_reply_t got_reply;
    bus_reply_t want_reply;

    int err_count       = 0;
    int cycle_count     = 0;
    int events_sent     = 0;
    int active_events   = 0;
    int replies_checked = 0;
    int words_written   = 0;
    int bytes_read      = 0;
    int src_idle_pct    = 20;
    int snk_idle_pct    = 68;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending", cycle_count,
                     pending_replies.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %02h expected %02h",
                                      replies_checked, name, got, want));
    endtask

    // word address: base plus index wraps at 16 bits, then folds into the store
    function automatic int store_slot();
        logic [WORD_W-1:0] a;
        a = base_addr + word_idx;
        return int'(a) % STORE_DEPTH;
    endfunction

    // next state and result of the target for one bus event
    function automatic bus_reply_t target_step(input logic [EV_W-1:0] ev,
                                               input logic [CODE_W-1:0] code,
                                               input logic rd,
                                               input logic [BYTE_W-1:0] rx);
        bus_reply_t    r;
        target_phase_t prev;
        logic          fault;
        logic          reading;
        r = '0;
        fault = 1'b0;
        prev = phase;
        reading = (phase == P_RD_HIGH) || (phase == P_RD_LOW);
        if (phase != P_HALTED && ev <= EV_BUS_ERR)
        begin
            case (ev)
                EV_ADDR:
                begin
                    if (phase == P_IDLE)
                    begin
                        if (code == own_addr)
                        begin
                            if (rd)
                                fault = 1'b1;
                            else
                            begin
                                word_idx = '0;
                                phase = P_REG_LO;
                            end
                        end
                    end
                    else if (phase == P_REG_DONE)
                    begin
                        if (code == own_addr)
                        begin
                            if (!rd)
                                fault = 1'b1;
                            else
                            begin
                                data_word = reg_store[store_slot()];
                                r.tx_valid = 1'b1;
                                r.tx_byte = data_word[7:0];
                                phase = P_RD_HIGH;
                            end
                        end
                    end
                    else
                        fault = 1'b1;
                end
                EV_BYTE:
                begin
                    case (phase)
                        P_REG_LO:
                        begin
                            base_addr[7:0] = rx;
                            phase = P_REG_HI;
                        end
                        P_REG_HI:
                        begin
                            base_addr[15:8] = rx;
                            phase = P_REG_DONE;
                        end
                        P_REG_DONE, P_WR_NEXT:
                        begin
                            data_word[7:0] = rx;
                            phase = P_WR_HIGH;
                        end
                        P_WR_HIGH:
                        begin
                            data_word[15:8] = rx;
                            reg_store[store_slot()] = data_word;
                            word_idx = word_idx + 16'd1;
                            words_written++;
                            phase = P_WR_NEXT;
                        end
                        default:
                            fault = 1'b1;
                    endcase
                end
                EV_TX_EMPTY:
                begin
                    if (phase == P_RD_HIGH)
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = data_word[15:8];
                        word_idx = word_idx + 16'd1;
                        data_word = reg_store[store_slot()];
                        phase = P_RD_LOW;
                    end
                    else if (phase == P_RD_LOW)
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_byte = data_word[7:0];
                        phase = P_RD_HIGH;
                    end
                    else
                        fault = 1'b1;
                end
                EV_STOP:
                begin
                    if (reading || phase == P_WR_NEXT)
                    begin
                        phase = P_IDLE;
                        r.txn_end = 1'b1;
                    end
                    else if (phase != P_IDLE && phase != P_REG_DONE)
                        fault = 1'b1;
                end
                EV_NACK:
                begin
                    if (reading)
                    begin
                        phase = P_IDLE;
                        r.txn_end = 1'b1;
                    end
                    else
                        fault = 1'b1;
                end
                default:
                    fault = 1'b1;
            endcase
        end
        if (fault)
        begin
            phase = P_HALTED;
            r = '0;
        end
        r.halted = (phase == P_HALTED);
        if (r.tx_valid || r.txn_end || phase != prev)
            active_events++;
        if (r.tx_valid)
            bytes_read++;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_reply = {rsp_ch.tx_valid, rsp_ch.tx_byte, rsp_ch.txn_end, rsp_ch.halted};
            if (pending_replies.size() == 0)
                report_mismatch($sformatf("result with nothing pending: %p", got_reply));
            else
            begin
                want_reply = pending_replies.pop_front();
                check_field("tx_valid", 8'(got_reply.tx_valid), 8'(want_reply.tx_valid));
                check_field("tx_byte", got_reply.tx_byte, want_reply.tx_byte);
                check_field("txn_end", 8'(got_reply.txn_end), 8'(want_reply.txn_end));
                check_field("halted", 8'(got_reply.halted), 8'(want_reply.halted));
                replies_checked++;
            end
        end
    end

    // result side stalls
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // one bus event transaction, predicted when accepted
    task automatic send_event(input logic [EV_W-1:0] ev, input logic [CODE_W-1:0] code,
                              input logic rd, input logic [BYTE_W-1:0] rx);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= ev;
        req_ch.match_code <= code;
        req_ch.dir_read   <= rd;
        req_ch.rx_byte    <= rx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_replies.push_back(target_step(ev, code, rd, rx));
        events_sent++;
    endtask

    task automatic send_addr(input logic [CODE_W-1:0] code, input logic rd);
        send_event(EV_ADDR, code, rd, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_event(EV_BYTE, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), b);
    endtask

    task automatic send_plain(input logic [EV_W-1:0] ev);
        send_event(ev, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)));
    endtask

    function automatic logic [CODE_W-1:0] foreign_code();
        logic [CODE_W-1:0] c;
        c = 7'($urandom_range(0, 127));
        if (c == own_addr)
            c = c ^ 7'd1;
        return c;
    endfunction

    // harmless events: undefined codes anywhere, foreign address or stop where ignored
    task automatic maybe_noise();
        int pick;
        if ($urandom_range(0, 99) < 8)
        begin
            pick = $urandom_range(0, 2);
            if (pick == 0 || !(phase == P_IDLE || phase == P_REG_DONE))
                send_plain($urandom_range(0, 1) ? EV_UNDEF_A : EV_UNDEF_B);
            else if (pick == 1)
                send_addr(foreign_code(), 1'($urandom_range(0, 1)));
            else
                send_plain(EV_STOP);
        end
    endtask

    // write header: own address, then register address low byte first
    task automatic send_reg_address(input logic [WORD_W-1:0] addr);
        send_addr(own_addr, 1'b0);
        maybe_noise();
        send_byte(addr[7:0]);
        maybe_noise();
        send_byte(addr[15:8]);
        maybe_noise();
    endtask

    // sender pauses until every result is back
    task automatic wait_all_replies();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_own_addr(input logic [CODE_W-1:0] a);
        wait_all_replies();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(negedge clk);
        cfg_we    <= 1'b0;
        own_addr = a;
    endtask

    function automatic logic [WORD_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return 16'($urandom_range(0, 47));
            4:          return 16'($urandom_range(0, 16'hFFFF));
            5:          return 16'(16'hFFFF - $urandom_range(0, 3));
            6:          return 16'(STORE_DEPTH * $urandom_range(1, 63) - $urandom_range(0, 2));
            default:    return 16'($urandom_range(0, 15) * 4096 + $urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // write burst with auto-increment, closed by stop
    task automatic run_write_txn();
        int               n;
        logic [WORD_W-1:0] w;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        send_reg_address(pick_base());
        repeat (n)
        begin
            w = pick_word();
            send_byte(w[7:0]);
            maybe_noise();
            send_byte(w[15:8]);
            maybe_noise();
        end
        send_plain(EV_STOP);
    endtask

    // register address, optional stop, repeated start read, closed by nack or stop
    task automatic run_read_txn();
        int n;
        send_reg_address(pick_base());
        if ($urandom_range(0, 1))
        begin
            send_plain(EV_STOP);
            maybe_noise();
        end
        send_addr(own_addr, 1'b1);
        maybe_noise();
        n = $urandom_range(0, 9);
        repeat (n)
        begin
            send_plain(EV_TX_EMPTY);
            maybe_noise();
        end
        send_plain($urandom_range(0, 1) ? EV_NACK : EV_STOP);
    endtask

    // field extremes, ignored events, write and read across the address wrap
    task automatic test_directed();
        write_own_addr(7'd0);
        send_addr(7'd127, 1'b0);
        send_plain(EV_STOP);
        send_plain(EV_UNDEF_A);
        send_plain(EV_UNDEF_B);
        send_addr(7'd0, 1'b0);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_plain(EV_STOP);
        send_addr(7'd0, 1'b0);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_plain(EV_STOP);
        send_addr(7'd127, 1'b1);
        send_addr(7'd0, 1'b1);
        send_plain(EV_TX_EMPTY);
        send_plain(EV_TX_EMPTY);
        send_plain(EV_TX_EMPTY);
        send_plain(EV_NACK);
    endtask

    // well-formed transactions with random content and some noise
    task automatic test_random(input int n_events, input int src_pct, input int snk_pct,
                               input logic [CODE_W-1:0] addr);
        int stop_at;
        write_own_addr(addr);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = events_sent + n_events;
        while (events_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:    run_write_txn();
                4, 5, 6, 7, 8: run_read_txn();
                default:
                begin
                    send_addr(foreign_code(), 1'($urandom_range(0, 1)));
                    send_plain(EV_STOP);
                end
            endcase
            if ($urandom_range(0, 99) < 2)
                wait_all_replies();
        end
    endtask

    // one randomly chosen fault, then events that must all be ignored
    task automatic test_halt();
        case ($urandom_range(0, 9))
            0: send_addr(own_addr, 1'b1);
            1:
            begin
                send_reg_address(pick_base());
                send_addr(own_addr, 1'b0);
            end
            2:
            begin
                send_reg_address(pick_base());
                send_byte(8'($urandom_range(0, 255)));
                send_plain(EV_STOP);
            end
            3: send_plain(EV_NACK);
            4: send_plain(EV_TX_EMPTY);
            5: send_byte(8'($urandom_range(0, 255)));
            6:
            begin
                send_reg_address(pick_base());
                send_addr(own_addr, 1'b1);
                send_byte(8'($urandom_range(0, 255)));
            end
            7:
            begin
                send_reg_address(pick_base());
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                send_addr(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            end
            8:
            begin
                send_addr(own_addr, 1'b0);
                send_plain(EV_STOP);
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    send_addr(own_addr, 1'b0);
                send_plain(EV_BUS_ERR);
            end
        endcase
        repeat (6)
            send_event(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // test sequence
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = '0;
        req_ch.match_code = '0;
        req_ch.dir_read   = 1'b0;
        req_ch.rx_byte    = '0;
        rsp_ch.ready      = 1'b0;
        own_addr          = '0;
        phase             = P_IDLE;
        base_addr         = '0;
        word_idx          = '0;
        data_word         = '0;
        foreach (reg_store[i])
            reg_store[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(RANDOM_EVENTS / 3, 20, 68, 7'd127);
        test_random(RANDOM_EVENTS / 3, 68, 20, 7'($urandom_range(1, 126)));
        test_random(RANDOM_EVENTS - 2 * (RANDOM_EVENTS / 3), 0, 0,
                    7'($urandom_range(0, 127)));
        test_halt();
        wait_all_replies();

        $display("covered %0d bus events (%0d acted on), %0d results checked", events_sent,
                 active_events, replies_checked);
        $display("%0d words stored, %0d bytes streamed out, four address settings, one halt",
                 words_written, bytes_read);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
